/* rtl/sjf_nonpreemptive_scheduler_unit_assert.svh */
// Assertion macros for the SJF scheduler checker.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH

// checked only outside reset
`define SJF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SJF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sjf_pkg.sv */
`default_nettype none
package sjf_pkg;
	localparam int MAX_JOBS_DEF  = 64;
	localparam int TIME_BITS_DEF = 16;

	localparam int IN_TIME_W = 16;
	localparam int JOB_NUM_W = 7;
	localparam int DUR_W     = 23;
	localparam int AVG_W     = 31;

	typedef struct packed {
		logic done;
		logic arrived;
	} pick_stat_t;
endpackage
`default_nettype wire

/* rtl/sjf_nonpreemptive_scheduler_unit.sv */
`default_nettype none
// Non-preemptive shortest-job-first scheduler. Jobs are loaded one per cycle
// (arrival, burst) into a job memory with one write and one read port; the job
// marked last_job starts scheduling and the input stays stalled until the whole
// batch has been emitted. Each pick is a scan over the job memory, one read a
// cycle; the final result also waits for a bit-serial divider that forms both
// Q8 averages. Results come out in run order through an output register, so the
// next scan overlaps a stalled output.
module sjf_nonpreemptive_scheduler_unit import sjf_pkg::*; #(
	parameter int MAX_JOBS  = MAX_JOBS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [IN_TIME_W-1:0] arrival_time,
	input  wire logic [IN_TIME_W-1:0] burst_time,
	input  wire logic                 last_job,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [JOB_NUM_W-1:0] job_number,
	output logic      [IN_TIME_W-1:0] job_arrival,
	output logic      [IN_TIME_W-1:0] job_burst,
	output logic      [DUR_W-1:0]     wait_time,
	output logic      [DUR_W-1:0]     turnaround_time,
	output logic      [AVG_W-1:0]     avg_wait_q8,
	output logic      [AVG_W-1:0]     avg_turnaround_q8,
	output logic                      last_result
);
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int CT_W  = TIME_BITS + $clog2(MAX_JOBS) + 1;
	localparam int TOT_W = CT_W + $clog2(MAX_JOBS);
	localparam int NUM_W = TOT_W + 8;

	typedef enum logic [1:0] {LOAD, SCAN, DIV, EMIT} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q, k_q;
	logic [CT_W-1:0]      time_q;
	logic [TOT_W-1:0]     wtot_q, ttot_q;
	logic [MAX_JOBS-1:0]  done_q;
	logic                 pick_start_q, div_start_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [TIME_BITS-1:0] res_arr_q, res_burst_q;
	logic [CT_W-1:0]      res_wt_q, res_tt_q;
	logic                 res_last_q;
	logic                 out_valid_q, out_last_q;
	logic [JOB_NUM_W-1:0] out_num_q;
	logic [IN_TIME_W-1:0] out_arr_q, out_burst_q;
	logic [DUR_W-1:0]     out_wt_q, out_tt_q;
	logic [AVG_W-1:0]     out_aw_q, out_at_q;

	logic                   mem_we, mem_re, in_xfer, out_free;
	logic [IDX_W-1:0]       mem_raddr;
	logic [2*TIME_BITS-1:0] mem_rdata;
	pick_stat_t             pstat;
	logic [IDX_W-1:0]       sel_idx;
	logic [TIME_BITS-1:0]   sel_arr, sel_burst;
	logic [CT_W-1:0]        sel_start, finish, wt, tt;
	logic                   div_done;
	logic [NUM_W-1:0]       quo_w, quo_t;

	assign in_stall = (state_q != LOAD);
	assign in_xfer  = in_valid && (state_q == LOAD);
	assign mem_we   = in_xfer && (cnt_q < CNT_W'(MAX_JOBS));
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = sel_start + CT_W'(sel_burst);
	assign wt       = sel_start - CT_W'(sel_arr);
	assign tt       = wt + CT_W'(sel_burst);

	sjf_mem #(.DEPTH(MAX_JOBS), .WIDTH(2 * TIME_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({TIME_BITS'(arrival_time), TIME_BITS'(burst_time)}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sjf_pick #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_pick (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (pick_start_q),
		.cnt        (cnt_q),
		.now        (time_q),
		.done_flags (done_q),
		.rd_en      (mem_re),
		.rd_addr    (mem_raddr),
		.rd_data    (mem_rdata),
		.stat       (pstat),
		.sel_idx    (sel_idx),
		.sel_arr    (sel_arr),
		.sel_burst  (sel_burst),
		.sel_start  (sel_start)
	);

	sjf_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num_a  ({wtot_q, 8'd0}),
		.num_b  ({ttot_q, 8'd0}),
		.den    (cnt_q),
		.done   (div_done),
		.quo_a  (quo_w),
		.quo_b  (quo_t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= LOAD;
			cnt_q        <= '0;
			k_q          <= '0;
			time_q       <= '0;
			wtot_q       <= '0;
			ttot_q       <= '0;
			done_q       <= '0;
			pick_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			res_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			pick_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				LOAD: begin
					if (in_xfer) begin
						if (mem_we) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (last_job) begin
							pick_start_q <= 1'b1;
							state_q      <= SCAN;
						end
					end
				end
				SCAN: begin
					if (pstat.done) begin
						done_q[sel_idx] <= 1'b1;
						time_q      <= finish;
						wtot_q      <= wtot_q + TOT_W'(wt);
						ttot_q      <= ttot_q + TOT_W'(tt);
						k_q         <= k_q + CNT_W'(1);
						res_idx_q   <= sel_idx;
						res_arr_q   <= sel_arr;
						res_burst_q <= sel_burst;
						res_wt_q    <= wt;
						res_tt_q    <= tt;
						if (k_q + CNT_W'(1) == cnt_q) begin
							res_last_q  <= 1'b1;
							div_start_q <= 1'b1;
							state_q     <= DIV;
						end else begin
							res_last_q <= 1'b0;
							state_q    <= EMIT;
						end
					end
				end
				DIV: begin
					if (div_done) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_num_q   <= JOB_NUM_W'(res_idx_q) + JOB_NUM_W'(1);
						out_arr_q   <= IN_TIME_W'(res_arr_q);
						out_burst_q <= IN_TIME_W'(res_burst_q);
						out_wt_q    <= DUR_W'(res_wt_q);
						out_tt_q    <= DUR_W'(res_tt_q);
						out_last_q  <= res_last_q;
						out_aw_q    <= res_last_q ? AVG_W'(quo_w) : '0;
						out_at_q    <= res_last_q ? AVG_W'(quo_t) : '0;
						if (res_last_q) begin
							cnt_q   <= '0;
							k_q     <= '0;
							time_q  <= '0;
							wtot_q  <= '0;
							ttot_q  <= '0;
							done_q  <= '0;
							state_q <= LOAD;
						end else begin
							pick_start_q <= 1'b1;
							state_q      <= SCAN;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign job_number        = out_num_q;
	assign job_arrival       = out_arr_q;
	assign job_burst         = out_burst_q;
	assign wait_time         = out_wt_q;
	assign turnaround_time   = out_tt_q;
	assign avg_wait_q8       = out_aw_q;
	assign avg_turnaround_q8 = out_at_q;
	assign last_result       = out_last_q;
endmodule
`default_nettype wire

/* rtl/sjf_mem.sv */
`default_nettype none
module sjf_mem import sjf_pkg::*; #(
	parameter int DEPTH = MAX_JOBS_DEF,
	parameter int WIDTH = 2 * TIME_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/sjf_pick.sv */
`default_nettype none
module sjf_pick import sjf_pkg::*; #(
	parameter int MAX_JOBS  = MAX_JOBS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_JOBS),
	localparam int CNT_W = $clog2(MAX_JOBS + 1),
	localparam int CT_W  = TIME_BITS + $clog2(MAX_JOBS) + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [CNT_W-1:0]       cnt,
	input  wire logic [CT_W-1:0]        now,
	input  wire logic [MAX_JOBS-1:0]    done_flags,
	output logic                        rd_en,
	output logic      [IDX_W-1:0]       rd_addr,
	input  wire logic [2*TIME_BITS-1:0] rd_data,
	output pick_stat_t                  stat,
	output logic      [IDX_W-1:0]       sel_idx,
	output logic      [TIME_BITS-1:0]   sel_arr,
	output logic      [TIME_BITS-1:0]   sel_burst,
	output logic      [CT_W-1:0]        sel_start
);
	logic                 busy_q, vld_s1, last_s1, done_q;
	logic [IDX_W-1:0]     addr_q, idx_s1;
	logic                 a_found_q, e_found_q;
	logic [IDX_W-1:0]     a_idx_q, e_idx_q;
	logic [TIME_BITS-1:0] a_arr_q, a_burst_q, e_arr_q, e_burst_q;
	logic [TIME_BITS-1:0] d_arr, d_burst;
	logic                 last_addr, arrived, a_better, e_better, take;

	assign d_arr     = rd_data[2*TIME_BITS-1:TIME_BITS];
	assign d_burst   = rd_data[TIME_BITS-1:0];
	assign last_addr = (CNT_W'(addr_q) == cnt - CNT_W'(1));
	assign rd_en     = busy_q;
	assign rd_addr   = addr_q;
	assign take      = vld_s1 && !done_flags[idx_s1];
	assign arrived   = (CT_W'(d_arr) <= now);
	assign a_better  = !a_found_q || (d_burst < a_burst_q) ||
		((d_burst == a_burst_q) && (d_arr < a_arr_q));
	assign e_better  = !e_found_q || (d_arr < e_arr_q) ||
		((d_arr == e_arr_q) && (d_burst < e_burst_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			a_found_q <= 1'b0;
			e_found_q <= 1'b0;
		end else begin
			done_q  <= vld_s1 && last_s1;
			vld_s1  <= busy_q;
			last_s1 <= busy_q && last_addr;
			idx_s1  <= addr_q;
			if (start) begin
				busy_q    <= 1'b1;
				addr_q    <= '0;
				a_found_q <= 1'b0;
				e_found_q <= 1'b0;
			end else if (busy_q) begin
				addr_q <= addr_q + IDX_W'(1);
				if (last_addr) begin
					busy_q <= 1'b0;
				end
			end
			if (take && arrived && a_better) begin
				a_found_q <= 1'b1;
				a_idx_q   <= idx_s1;
				a_arr_q   <= d_arr;
				a_burst_q <= d_burst;
			end
			if (take && e_better) begin
				e_found_q <= 1'b1;
				e_idx_q   <= idx_s1;
				e_arr_q   <= d_arr;
				e_burst_q <= d_burst;
			end
		end
	end

	assign stat.done    = done_q;
	assign stat.arrived = a_found_q;
	assign sel_idx      = a_found_q ? a_idx_q : e_idx_q;
	assign sel_arr      = a_found_q ? a_arr_q : e_arr_q;
	assign sel_burst    = a_found_q ? a_burst_q : e_burst_q;
	assign sel_start    = a_found_q ? now : CT_W'(e_arr_q);
endmodule
`default_nettype wire

/* rtl/sjf_div.sv */
`default_nettype none
module sjf_div import sjf_pkg::*; #(
	parameter int NUM_W = 37,
	parameter int DEN_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num_a,
	input  wire logic [NUM_W-1:0] num_b,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo_a,
	output logic      [NUM_W-1:0] quo_b
);
	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] qa_q, qb_q;
	logic [DEN_W-1:0] ra_q, rb_q;
	logic [DEN_W:0]   ra2, rb2, ra_d, rb_d;
	logic             ge_a, ge_b;

	assign ra2  = {ra_q, qa_q[NUM_W-1]};
	assign rb2  = {rb_q, qb_q[NUM_W-1]};
	assign ge_a = (ra2 >= {1'b0, den});
	assign ge_b = (rb2 >= {1'b0, den});
	assign ra_d = ge_a ? ra2 - {1'b0, den} : ra2;
	assign rb_d = ge_b ? rb2 - {1'b0, den} : rb2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
				qa_q   <= num_a;
				qb_q   <= num_b;
				ra_q   <= '0;
				rb_q   <= '0;
			end else if (busy_q) begin
				qa_q  <= {qa_q[NUM_W-2:0], ge_a};
				qb_q  <= {qb_q[NUM_W-2:0], ge_b};
				ra_q  <= ra_d[DEN_W-1:0];
				rb_q  <= rb_d[DEN_W-1:0];
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign quo_a = qa_q;
	assign quo_b = qb_q;
endmodule
`default_nettype wire

/* rtl/sjf_chk.sv */
`default_nettype none
`include "sjf_nonpreemptive_scheduler_unit_assert.svh"
module sjf_chk import sjf_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [IN_TIME_W-1:0] arrival_time,
	input wire logic [IN_TIME_W-1:0] burst_time,
	input wire logic                 last_job,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [JOB_NUM_W-1:0] job_number,
	input wire logic [IN_TIME_W-1:0] job_arrival,
	input wire logic [IN_TIME_W-1:0] job_burst,
	input wire logic [DUR_W-1:0]     wait_time,
	input wire logic [DUR_W-1:0]     turnaround_time,
	input wire logic [AVG_W-1:0]     avg_wait_q8,
	input wire logic [AVG_W-1:0]     avg_turnaround_q8,
	input wire logic                 last_result
);
	`SJF_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !out_valid, "out_valid after reset")
	`SJF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(job_number) && $stable(wait_time), "stalled result changed")
	`SJF_ASSERT(a_avg_zero, out_valid && !last_result |-> avg_wait_q8 == '0 && avg_turnaround_q8 == '0, "average on non-final result")
	`SJF_ASSERT(a_tt_sum, out_valid |-> turnaround_time == wait_time + DUR_W'(job_burst), "turnaround not wait plus burst")
	`SJF_ASSERT(a_job_num, out_valid |-> job_number != '0, "job number zero")
endmodule

bind sjf_nonpreemptive_scheduler_unit sjf_chk u_sjf_chk (.*);
`default_nettype wire
